/* rtl/periodic_oneshot_alarm_table_assert.svh */
// Assertion macros used by the alarm table datapath.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef PERIODIC_ONESHOT_ALARM_TABLE_ASSERT_SVH
`define PERIODIC_ONESHOT_ALARM_TABLE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PAT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("alarm table assertion failed");
`define PAT_ASSERT_NEVER(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) \
    else $error("alarm table forbidden condition");
`else
`define PAT_ASSERT(lbl, prop)
`define PAT_ASSERT_NEVER(lbl, prop)
`endif
`endif

/* rtl/pat_pkg.sv */
// Package of the alarm table: sizes, codes and the command and status
// structs that join the controller and the datapath. No dependencies.
package pat_pkg;
  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int TIME_W = 40;
  localparam int ID_W = 32;
  localparam int PER_W = 32;
  localparam int THR_W = 32;

  localparam logic [TIME_W-1:0] MIN_VALID_RST = TIME_W'(64'd1000000000);
  localparam logic [THR_W-1:0] THRESHOLD_RST = THR_W'(120);

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic [1:0] RK_STATUS = 2'd0;
  localparam logic [1:0] RK_FIRED = 2'd1;
  localparam logic [1:0] RK_OVERDUE = 2'd2;
  localparam logic [1:0] RK_DONE = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  localparam logic CFG_MIN_VALID = 1'b0;
  localparam logic CFG_THRESHOLD = 1'b1;

  typedef struct packed {
    logic       load;
    logic       idx_inc;
    logic       add_wr;
    logic       drop;
    logic       disable_ent;
    logic       fire_upd;
    logic       chg_set;
    logic       emit;
    logic [1:0] emit_kind;
    logic [1:0] emit_status;
  } cmd_t;

  typedef struct packed {
    logic       out_free;
    logic       idx_end;
    logic       full;
    logic       match;
    logic       unsynced;
    logic       hit;
    logic       overdue;
    logic       oneshot;
    logic       del;
    logic [1:0] opcode;
  } stat_t;
endpackage

/* rtl/pat_ctrl.sv */
// Controller of the alarm table: sequences add, remove and tick scans.
// Depends on pat_pkg; drives pat_dp through cmd_t and reads stat_t.
module pat_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pat_pkg::stat_t stat_i,
  output pat_pkg::cmd_t  cmd_o
);
  typedef enum logic [2:0] {S_IDLE, S_ADD, S_RM, S_TICK, S_FIN} state_e;
  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
        end
      end
      S_ADD: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.emit_kind = pat_pkg::RK_STATUS;
          cmd_o.emit_status = stat_i.full ? pat_pkg::ST_FULL : pat_pkg::ST_OK;
          cmd_o.add_wr = !stat_i.full;
          state_d = S_IDLE;
        end
      end
      S_RM: begin
        if (stat_i.idx_end) begin
          if (stat_i.out_free) begin
            cmd_o.emit = 1'b1;
            cmd_o.emit_kind = pat_pkg::RK_STATUS;
            cmd_o.emit_status = pat_pkg::ST_NOT_FOUND;
            state_d = S_IDLE;
          end
        end else if (stat_i.match) begin
          if (stat_i.out_free) begin
            cmd_o.emit = 1'b1;
            cmd_o.emit_kind = pat_pkg::RK_STATUS;
            cmd_o.emit_status = pat_pkg::ST_OK;
            cmd_o.drop = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_TICK: begin
        if (stat_i.unsynced || stat_i.idx_end) begin
          state_d = S_FIN;
        end else if (!stat_i.hit) begin
          cmd_o.idx_inc = 1'b1;
        end else if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.chg_set = 1'b1;
          if (stat_i.overdue) begin
            cmd_o.emit_kind = pat_pkg::RK_OVERDUE;
            cmd_o.disable_ent = 1'b1;
            cmd_o.idx_inc = 1'b1;
          end else begin
            cmd_o.emit_kind = pat_pkg::RK_FIRED;
            if (stat_i.oneshot && stat_i.del) begin
              cmd_o.drop = 1'b1;
            end else begin
              cmd_o.fire_upd = 1'b1;
              cmd_o.idx_inc = 1'b1;
            end
          end
        end
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.emit_kind = pat_pkg::RK_DONE;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      if (state_q == S_IDLE && in_valid_i) begin
        case (stat_i.opcode)
          pat_pkg::OP_ADD: state_q <= S_ADD;
          pat_pkg::OP_REMOVE: state_q <= S_RM;
          pat_pkg::OP_TICK: state_q <= S_TICK;
          default: state_q <= S_IDLE;
        endcase
      end else begin
        state_q <= state_d;
      end
    end
  end
endmodule

/* rtl/pat_dp.sv */
// Datapath of the alarm table: entry storage, scan index, time arithmetic
// and the output register. Depends on pat_pkg and the assertion header.
`include "periodic_oneshot_alarm_table_assert.svh"
module pat_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pat_pkg::cmd_t                 cmd_i,
  output pat_pkg::stat_t                stat_o,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_index_i,
  input  logic [pat_pkg::TIME_W-1:0]    cfg_data_i,
  input  logic [1:0]                    opcode_i,
  input  logic [pat_pkg::TIME_W-1:0]    now_time_i,
  input  logic [pat_pkg::ID_W-1:0]      entry_id_i,
  input  logic                          entry_kind_i,
  input  logic [pat_pkg::PER_W-1:0]     period_secs_i,
  input  logic [pat_pkg::TIME_W-1:0]    alarm_time_i,
  input  logic                          delete_when_done_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    result_kind_o,
  output logic [1:0]                    status_o,
  output logic [pat_pkg::ID_W-1:0]      event_id_o,
  output logic [pat_pkg::TIME_W-1:0]    event_time_o,
  output logic [pat_pkg::TIME_W-1:0]    late_by_o,
  output logic                          table_changed_o,
  output logic                          last_o
);
  localparam int N = pat_pkg::MAX_ENTRIES;
  localparam int TW = pat_pkg::TIME_W;
  localparam int IDX_SEL_W = pat_pkg::IDX_W;

  logic [TW-1:0] min_valid_q;
  logic [pat_pkg::THR_W-1:0] thr_q;
  logic [pat_pkg::CNT_W-1:0] count_q;
  logic [pat_pkg::CNT_W-1:0] idx_q;
  logic chg_q;

  logic [1:0] op_q;
  logic [TW-1:0] now_q, at_q;
  logic [pat_pkg::ID_W-1:0] id_q;
  logic kind_q, del_q;
  logic [pat_pkg::PER_W-1:0] per_q;

  logic [pat_pkg::ID_W-1:0] ids_q [N];
  logic kinds_q [N];
  logic en_q [N];
  logic delf_q [N];
  logic [pat_pkg::PER_W-1:0] ivl_q [N];
  logic [TW-1:0] atm_q [N];
  logic [TW-1:0] due_q [N];
  logic [TW-1:0] lastf_q [N];

  logic out_valid_q;
  logic [1:0] rk_q, st_q;
  logic [pat_pkg::ID_W-1:0] eid_q;
  logic [TW-1:0] etime_q, late_q;
  logic chg_out_q;

  logic [IDX_SEL_W-1:0] ix;
  logic [IDX_SEL_W-1:0] wx;
  logic [TW:0] add_sum, tick_sum;
  logic [TW-1:0] add_due, tick_due, cur_due, late;
  logic add_en;

  assign ix = idx_q[IDX_SEL_W-1:0];
  assign wx = count_q[IDX_SEL_W-1:0];

  assign add_sum = {1'b0, now_q} + {{(TW + 1 - pat_pkg::PER_W){1'b0}}, per_q};
  assign add_en = !kind_q || (at_q > now_q);
  assign add_due = !kind_q ? (add_sum[TW] ? {TW{1'b1}} : add_sum[TW-1:0])
                           : (add_en ? at_q : '0);
  assign tick_sum = {1'b0, now_q} + {{(TW + 1 - pat_pkg::PER_W){1'b0}}, ivl_q[ix]};
  assign tick_due = tick_sum[TW] ? {TW{1'b1}} : tick_sum[TW-1:0];
  assign cur_due = kinds_q[ix] ? atm_q[ix] : due_q[ix];
  assign late = now_q - atm_q[ix];

  always_comb begin
    stat_o = '0;
    stat_o.out_free = !out_valid_q || out_ready_i;
    stat_o.idx_end = (idx_q >= count_q);
    stat_o.full = (count_q >= pat_pkg::CNT_W'(N));
    stat_o.match = (ids_q[ix] == id_q);
    stat_o.unsynced = (now_q < min_valid_q);
    stat_o.hit = en_q[ix] && (cur_due != '0) && (cur_due <= now_q);
    stat_o.overdue = kinds_q[ix] && (late > {{(TW - pat_pkg::THR_W){1'b0}}, thr_q})
                     && (lastf_q[ix] == '0);
    stat_o.oneshot = kinds_q[ix];
    stat_o.del = delf_q[ix];
    stat_o.opcode = cmd_i.load ? opcode_i : op_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_valid_q <= pat_pkg::MIN_VALID_RST;
      thr_q <= pat_pkg::THRESHOLD_RST;
      count_q <= '0;
      idx_q <= '0;
      chg_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == pat_pkg::CFG_MIN_VALID) begin
          min_valid_q <= cfg_data_i;
        end else begin
          thr_q <= cfg_data_i[pat_pkg::THR_W-1:0];
        end
      end
      if (cmd_i.load) begin
        idx_q <= '0;
        chg_q <= 1'b0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.chg_set) begin
        chg_q <= 1'b1;
      end
      if (cmd_i.add_wr) begin
        count_q <= count_q + 1'b1;
      end else if (cmd_i.drop) begin
        count_q <= count_q - 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= opcode_i;
      now_q <= now_time_i;
      id_q <= entry_id_i;
      kind_q <= entry_kind_i;
      per_q <= period_secs_i;
      at_q <= alarm_time_i;
      del_q <= delete_when_done_i;
    end
    if (cmd_i.add_wr) begin
      ids_q[wx] <= id_q;
      kinds_q[wx] <= kind_q;
      en_q[wx] <= add_en;
      delf_q[wx] <= del_q;
      ivl_q[wx] <= per_q;
      atm_q[wx] <= at_q;
      due_q[wx] <= add_due;
      lastf_q[wx] <= '0;
    end
    if (cmd_i.drop) begin
      for (int j = 0; j < N - 1; j++) begin
        if (j >= int'(ix)) begin
          ids_q[j] <= ids_q[j+1];
          kinds_q[j] <= kinds_q[j+1];
          en_q[j] <= en_q[j+1];
          delf_q[j] <= delf_q[j+1];
          ivl_q[j] <= ivl_q[j+1];
          atm_q[j] <= atm_q[j+1];
          due_q[j] <= due_q[j+1];
          lastf_q[j] <= lastf_q[j+1];
        end
      end
    end
    if (cmd_i.disable_ent) begin
      en_q[ix] <= 1'b0;
    end
    if (cmd_i.fire_upd) begin
      lastf_q[ix] <= now_q;
      if (kinds_q[ix]) begin
        en_q[ix] <= 1'b0;
        due_q[ix] <= '0;
      end else begin
        due_q[ix] <= tick_due;
      end
    end
    if (cmd_i.emit) begin
      rk_q <= cmd_i.emit_kind;
      st_q <= cmd_i.emit_status;
      case (cmd_i.emit_kind)
        pat_pkg::RK_STATUS: begin
          eid_q <= '0;
          etime_q <= (op_q == pat_pkg::OP_ADD && cmd_i.emit_status == pat_pkg::ST_OK)
                     ? add_due : '0;
          late_q <= '0;
          chg_out_q <= 1'b0;
        end
        pat_pkg::RK_FIRED: begin
          eid_q <= ids_q[ix];
          etime_q <= '0;
          late_q <= '0;
          chg_out_q <= 1'b0;
        end
        pat_pkg::RK_OVERDUE: begin
          eid_q <= ids_q[ix];
          etime_q <= atm_q[ix];
          late_q <= late;
          chg_out_q <= 1'b0;
        end
        default: begin
          eid_q <= '0;
          etime_q <= '0;
          late_q <= '0;
          chg_out_q <= chg_q;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_kind_o = rk_q;
  assign status_o = st_q;
  assign event_id_o = eid_q;
  assign event_time_o = etime_q;
  assign late_by_o = late_q;
  assign table_changed_o = chg_out_q;
  assign last_o = (rk_q == pat_pkg::RK_STATUS) || (rk_q == pat_pkg::RK_DONE);

  `PAT_ASSERT_NEVER(a_count_range, count_q > pat_pkg::CNT_W'(N))
  `PAT_ASSERT_NEVER(a_add_full, cmd_i.add_wr && stat_o.full)
  `PAT_ASSERT_NEVER(a_drop_empty, cmd_i.drop && (count_q == '0))
  `PAT_ASSERT(a_emit_free, cmd_i.emit |-> stat_o.out_free)
endmodule

/* rtl/periodic_oneshot_alarm_table.sv */
// Alarm table of periodic and one-shot entries with add, remove and tick.
// Top level; depends on pat_pkg, pat_ctrl and pat_dp.
//
// Input beats carry an opcode and its operands on valid/ready; one beat is
// taken only while the block is idle. Result beats leave through a single
// output register on valid/ready; last marks the final beat of an item.
// An add gives one status beat once the output register is free. A remove
// walks the table one entry per cycle and gives one status beat. A tick
// walks the table one entry per cycle while the receiver keeps up, emits a
// fired or overdue beat for each due entry, then a done beat; when now is
// below the minimum valid time it gives only the done beat. A stalled
// receiver holds the controller at each beat until the output register
// frees; no beat is lost. Configuration writes are always taken.
// Reset empties the table and loads the default register values.
module periodic_oneshot_alarm_table (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic                       cfg_index_i,
  input  logic [pat_pkg::TIME_W-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 opcode_i,
  input  logic [pat_pkg::TIME_W-1:0] now_time_i,
  input  logic [pat_pkg::ID_W-1:0]   entry_id_i,
  input  logic                       entry_kind_i,
  input  logic [pat_pkg::PER_W-1:0]  period_secs_i,
  input  logic [pat_pkg::TIME_W-1:0] alarm_time_i,
  input  logic                       delete_when_done_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 result_kind_o,
  output logic [1:0]                 status_o,
  output logic [pat_pkg::ID_W-1:0]   event_id_o,
  output logic [pat_pkg::TIME_W-1:0] event_time_o,
  output logic [pat_pkg::TIME_W-1:0] late_by_o,
  output logic                       table_changed_o,
  output logic                       last_o
);
  pat_pkg::cmd_t cmd;
  pat_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  pat_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .stat_i(stat), .cmd_o(cmd)
  );

  pat_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .cfg_valid_i, .cfg_index_i, .cfg_data_i,
    .opcode_i, .now_time_i, .entry_id_i, .entry_kind_i,
    .period_secs_i, .alarm_time_i, .delete_when_done_i,
    .out_valid_o, .out_ready_i, .result_kind_o, .status_o,
    .event_id_o, .event_time_o, .late_by_o, .table_changed_o, .last_o
  );
endmodule
